// File: hw/rtl/pdll_pkg.sv
package pdll_pkg;

  localparam int unsigned PoolNodes = 16;
  localparam int unsigned ItemBits  = 32;

  typedef enum logic [3:0] {
    OpPushFront  = 4'd0,
    OpPushBack   = 4'd1,
    OpInsert     = 4'd2,
    OpPopFront   = 4'd3,
    OpPopBack    = 4'd4,
    OpErase      = 4'd5,
    OpFind       = 4'd6,
    OpFront      = 4'd7,
    OpBack       = 4'd8,
    OpReadAt     = 4'd9,
    OpNext       = 4'd10,
    OpPrev       = 4'd11,
    OpClear      = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StFull      = 3'd1,
    StEmpty     = 3'd2,
    StNotInList = 3'd3,
    StNotFound  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SFind,
    SClear,
    SLink,
    SDone
  } state_e;

  localparam logic [1:0] AddrCapacity = 2'd0;

  typedef struct packed {
    logic [3:0]          operation;
    logic [3:0]          node_handle;
    logic [ItemBits-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [3:0]          result_node;
    logic                node_valid;
    logic [ItemBits-1:0] read_value;
    logic [4:0]          item_count;
    logic                is_empty;
    logic                is_full;
  } rsp_t;

endpackage

// File: hw/rtl/pooled_doubly_linked_list.sv
// channel   | direction | handshake           | payload
// request   | in        | start_i && !busy_o  | req_i (operation, node_handle, item_value)
// result    | out       | done_o (one cycle)  | rsp_o (status, node, value, count, flags)
// config    | in        | apb write access    | capacity_limit at address 0
//
// simple operations: after the accept edge the request passes through SLink, then done_o
// rises in SDone, and the next request is taken once the block is back in SIdle
// find compares one node per cycle through the shared compare unit;
// clear releases one node per cycle, head first
// reset: list empty, all nodes free, the first node given out is the highest
// done_o cannot be stalled; busy_o stays high until the result has been shown
module pooled_doubly_linked_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pdll_pkg::req_t     req_i,
  output logic               done_o,
  output pdll_pkg::rsp_t     rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned N = pdll_pkg::PoolNodes;
  localparam logic [4:0] NONE = 5'(N);

  // node storage
  logic [pdll_pkg::ItemBits-1:0] item_q [N];
  logic [4:0]  next_q [N];
  logic [4:0]  prev_q [N];
  logic [N-1:0] mark_q;
  logic [3:0]  free_q [N];
  logic [4:0]  free_top_q, head_q, tail_q, count_q;
  logic [4:0]  limit_q;

  pdll_pkg::state_e state_q, state_d;
  pdll_pkg::req_t   req_q;
  pdll_pkg::rsp_t   rsp_q, rsp_d;
  logic [4:0]  walk_q;   // node under the find walker
  logic [4:0]  steps_q;

  logic [4:0] eff_limit;
  logic       full;
  logic       hit;       // the shared compare unit

  always_comb begin
    if (limit_q == 5'd0) eff_limit = 5'd1;
    else if (limit_q > 5'(N)) eff_limit = 5'(N);
    else eff_limit = limit_q;
  end
  assign full = (count_q >= eff_limit) || (free_top_q == 5'd0);
  assign hit  = (walk_q < NONE) && (item_q[walk_q[3:0]] == req_q.item_value);

  assign pready = 1'b1;
  assign prdata = {27'd0, limit_q};
  assign busy_o = (state_q != pdll_pkg::SIdle);
  assign done_o = (state_q == pdll_pkg::SDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 5'd16;
    else if (psel && penable && pwrite && paddr == pdll_pkg::AddrCapacity)
      limit_q <= pwdata[4:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdll_pkg::SIdle:  if (start_i) state_d = pdll_pkg::SLink;
      pdll_pkg::SLink: begin
        if (req_q.operation == pdll_pkg::OpFind && head_q < NONE) state_d = pdll_pkg::SFind;
        else if (req_q.operation == pdll_pkg::OpClear && head_q < NONE)
          state_d = pdll_pkg::SClear;
        else state_d = pdll_pkg::SDone;
      end
      pdll_pkg::SFind:
        if (hit || walk_q >= NONE || steps_q >= 5'(N-1)) state_d = pdll_pkg::SDone;
      pdll_pkg::SClear:
        if (next_q[head_q[3:0]] >= NONE) state_d = pdll_pkg::SDone;
      pdll_pkg::SDone:  state_d = pdll_pkg::SIdle;
      default:          state_d = pdll_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pdll_pkg::SIdle;
    else state_q <= state_d;
  end

  // decode of the held request: node to take, node to remove, node to report
  logic [3:0] h, n;
  logic [4:0] t, pn;
  logic [4:0] rm, rp, rn, rd;
  logic       do_add, do_remove;
  always_comb begin
    h  = req_q.node_handle;
    n  = free_q[free_top_q[3:0] - 4'd1];
    t  = (req_q.operation == pdll_pkg::OpInsert) ? {1'b0, h} : head_q;
    pn = (t < NONE) ? prev_q[t[3:0]] : NONE;
    rm = (req_q.operation == pdll_pkg::OpErase) ? {1'b0, h} :
         (req_q.operation == pdll_pkg::OpPopFront) ? head_q : tail_q;
    rp = prev_q[rm[3:0]];
    rn = next_q[rm[3:0]];
    rd = NONE;
    do_add    = 1'b0;
    do_remove = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      pdll_pkg::SLink: begin
        rsp_d = '0;
        unique case (req_q.operation)
          pdll_pkg::OpPushFront, pdll_pkg::OpPushBack, pdll_pkg::OpInsert: begin
            if (full) rsp_d.status = pdll_pkg::StFull;
            else if (req_q.operation == pdll_pkg::OpInsert && !mark_q[h])
              rsp_d.status = pdll_pkg::StNotInList;
            else do_add = 1'b1;
          end
          pdll_pkg::OpPopFront, pdll_pkg::OpPopBack, pdll_pkg::OpErase: begin
            if (req_q.operation == pdll_pkg::OpErase && !mark_q[h])
              rsp_d.status = pdll_pkg::StNotInList;
            else if (rm >= NONE) rsp_d.status = pdll_pkg::StEmpty;
            else begin
              do_remove = 1'b1;
              rd = rm;
            end
          end
          pdll_pkg::OpFind: begin
            if (head_q >= NONE) rsp_d.status = pdll_pkg::StEmpty;
            else rsp_d.status = pdll_pkg::StNotFound;
          end
          pdll_pkg::OpFront, pdll_pkg::OpBack: begin
            rd = (req_q.operation == pdll_pkg::OpFront) ? head_q : tail_q;
            if (rd >= NONE) rsp_d.status = pdll_pkg::StEmpty;
          end
          pdll_pkg::OpReadAt, pdll_pkg::OpNext, pdll_pkg::OpPrev: begin
            if (!mark_q[h]) rsp_d.status = pdll_pkg::StNotInList;
            else begin
              rd = (req_q.operation == pdll_pkg::OpReadAt) ? {1'b0, h} :
                   (req_q.operation == pdll_pkg::OpNext) ? next_q[h] : prev_q[h];
              if (rd >= NONE) rsp_d.status = pdll_pkg::StNotFound;
            end
          end
          default: ;
        endcase
        if (do_add) begin
          rsp_d.result_node = n;
          rsp_d.node_valid  = 1'b1;
          rsp_d.read_value  = req_q.item_value;
        end else if (rd < NONE) begin
          rsp_d.result_node = rd[3:0];
          rsp_d.node_valid  = 1'b1;
          rsp_d.read_value  = item_q[rd[3:0]];
        end
      end
      pdll_pkg::SFind: begin
        // one compare per cycle, walking next links from the head
        if (hit) begin
          rsp_d.status      = pdll_pkg::StOk;
          rsp_d.result_node = walk_q[3:0];
          rsp_d.node_valid  = 1'b1;
          rsp_d.read_value  = item_q[walk_q[3:0]];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pdll_pkg::SLink && do_add) item_q[n] <= req_q.item_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        next_q[i] <= NONE;
        prev_q[i] <= NONE;
        free_q[i] <= 4'(i);
      end
      mark_q     <= '0;
      free_top_q <= 5'(N);
      head_q     <= NONE;
      tail_q     <= NONE;
      count_q    <= '0;
      walk_q     <= '0;
      steps_q    <= '0;
      req_q      <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q <= rsp_d;
      unique case (state_q)
        pdll_pkg::SIdle: begin
          if (start_i) req_q <= req_i;
        end
        pdll_pkg::SLink: begin
          walk_q  <= head_q;
          steps_q <= '0;
          if (do_add) begin
            free_top_q <= free_top_q - 5'd1;
            mark_q[n]  <= 1'b1;
            count_q    <= count_q + 5'd1;
            if (req_q.operation == pdll_pkg::OpPushBack) begin
              prev_q[n] <= tail_q;
              next_q[n] <= NONE;
              if (tail_q < NONE) next_q[tail_q[3:0]] <= {1'b0, n};
              else head_q <= {1'b0, n};
              tail_q <= {1'b0, n};
            end else begin
              next_q[n] <= t;
              prev_q[n] <= pn;
              if (t < NONE) prev_q[t[3:0]] <= {1'b0, n};
              else tail_q <= {1'b0, n};
              if (pn < NONE) next_q[pn[3:0]] <= {1'b0, n};
              else head_q <= {1'b0, n};
            end
          end
          if (do_remove) begin
            if (rp < NONE) next_q[rp[3:0]] <= rn; else head_q <= rn;
            if (rn < NONE) prev_q[rn[3:0]] <= rp; else tail_q <= rp;
            mark_q[rm[3:0]] <= 1'b0;
            next_q[rm[3:0]] <= NONE;
            prev_q[rm[3:0]] <= NONE;
            free_q[free_top_q[3:0]] <= rm[3:0];
            free_top_q <= free_top_q + 5'd1;
            count_q    <= count_q - 5'd1;
          end
        end
        pdll_pkg::SFind: begin
          walk_q  <= next_q[walk_q[3:0]];
          steps_q <= steps_q + 5'd1;
        end
        pdll_pkg::SClear: begin
          // release the head node, one per cycle
          mark_q[head_q[3:0]] <= 1'b0;
          next_q[head_q[3:0]] <= NONE;
          prev_q[head_q[3:0]] <= NONE;
          free_q[free_top_q[3:0]] <= head_q[3:0];
          free_top_q <= free_top_q + 5'd1;
          count_q    <= count_q - 5'd1;
          if (next_q[head_q[3:0]] < NONE) prev_q[next_q[head_q[3:0]][3:0]] <= NONE;
          else tail_q <= NONE;
          head_q <= next_q[head_q[3:0]];
        end
        pdll_pkg::SDone: ;
        default: ;
      endcase
    end
  end

  // count and flags are taken live: the list has settled before done_o rises
  pdll_pkg::rsp_t rsp_view;
  always_comb begin
    rsp_view = rsp_q;
    rsp_view.item_count = count_q;
    rsp_view.is_empty   = (count_q == 5'd0);
    rsp_view.is_full    = (count_q >= eff_limit);
  end
  assign rsp_o = rsp_view;

  // free nodes plus listed nodes always fill the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_top_q + count_q) == 5'(N))
    else $error("pool accounting broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result shown twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NONE) == (count_q == 5'd0))
    else $error("head and count disagree");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  pdll_pkg::req_t   req_i;
  logic             done_o;
  pdll_pkg::rsp_t   rsp_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [1:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  pooled_doubly_linked_list dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int PoolN = int'(pdll_pkg::PoolNodes);
  localparam int NoLink = PoolN;
  // operation codes outside the supported set
  localparam logic [3:0] OpUnusedLo = 4'd13;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  // shadow copy of the pool
  logic [31:0] shadow_item [PoolN];
  int          shadow_next [PoolN];
  int          shadow_prev [PoolN];
  bit          shadow_used [PoolN];
  int          shadow_free [PoolN];
  int          free_depth;
  int          head_idx;
  int          tail_idx;
  int          list_len;
  logic [4:0]  cap_reg;

  pdll_pkg::req_t pending_reqs [$];
  pdll_pkg::rsp_t expected_rsps [$];
  int   errors;
  int   rsp_seen;
  int   op_hits [16];

  always #1 clk_i = ~clk_i;

  function automatic int cap_eff();
    if (cap_reg < 5'd1) return 1;
    if (int'(cap_reg) > PoolN) return PoolN;
    return int'(cap_reg);
  endfunction

  function automatic bit on_list(int n);
    return n < PoolN && shadow_used[n];
  endfunction

  // return a node to the free stack, dropping its links
  function automatic void drop_node(int n);
    int p;
    int q;
    p = shadow_prev[n];
    q = shadow_next[n];
    if (p < PoolN) shadow_next[p] = q; else head_idx = q;
    if (q < PoolN) shadow_prev[q] = p; else tail_idx = p;
    shadow_used[n] = 0;
    shadow_next[n] = NoLink;
    shadow_prev[n] = NoLink;
    if (free_depth < PoolN) begin
      shadow_free[free_depth] = n;
      free_depth++;
    end
    if (list_len > 0) list_len--;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < PoolN; i++) begin
      shadow_item[i] = '0;
      shadow_next[i] = NoLink;
      shadow_prev[i] = NoLink;
      shadow_used[i] = 0;
      shadow_free[i] = i;
    end
    free_depth = PoolN;
    head_idx = NoLink;
    tail_idx = NoLink;
    list_len = 0;
    cap_reg = 5'd16;
  endfunction

  // apply one request to the shadow list and return the response it gives
  function automatic pdll_pkg::rsp_t list_apply(pdll_pkg::req_t rq);
    pdll_pkg::rsp_t r;
    int n;
    int t;
    int h;
    bit ok;
    r = '0;
    h = int'(rq.node_handle);
    ok = 0;
    case (rq.operation)
      pdll_pkg::OpPushFront, pdll_pkg::OpPushBack, pdll_pkg::OpInsert: begin
        if (list_len >= cap_eff() || free_depth == 0) begin
          r.status = pdll_pkg::StFull;
        end else if (rq.operation == pdll_pkg::OpInsert && !on_list(h)) begin
          r.status = pdll_pkg::StNotInList;
        end else begin
          free_depth--;
          n = shadow_free[free_depth];
          shadow_item[n] = rq.item_value;
          shadow_used[n] = 1;
          if (rq.operation == pdll_pkg::OpPushBack) begin
            shadow_prev[n] = tail_idx;
            shadow_next[n] = NoLink;
            if (tail_idx < PoolN) shadow_next[tail_idx] = n; else head_idx = n;
            tail_idx = n;
          end else begin
            t = (rq.operation == pdll_pkg::OpInsert) ? h : head_idx;
            shadow_next[n] = t;
            if (t < PoolN) begin
              shadow_prev[n] = shadow_prev[t];
              shadow_prev[t] = n;
            end else begin
              shadow_prev[n] = NoLink;
              tail_idx = n;
            end
            if (shadow_prev[n] < PoolN) shadow_next[shadow_prev[n]] = n;
            else head_idx = n;
          end
          list_len++;
          r.result_node = 4'(n);
          r.read_value = rq.item_value;
          ok = 1;
        end
      end
      pdll_pkg::OpPopFront, pdll_pkg::OpPopBack, pdll_pkg::OpErase: begin
        if (rq.operation == pdll_pkg::OpErase) n = on_list(h) ? h : -1;
        else n = (rq.operation == pdll_pkg::OpPopFront) ? head_idx : tail_idx;
        if (n < 0) r.status = pdll_pkg::StNotInList;
        else if (n >= PoolN) r.status = pdll_pkg::StEmpty;
        else begin
          r.result_node = 4'(n);
          r.read_value = shadow_item[n];
          ok = 1;
          drop_node(n);
        end
      end
      pdll_pkg::OpFind: begin
        if (head_idx >= PoolN) r.status = pdll_pkg::StEmpty;
        else begin
          r.status = pdll_pkg::StNotFound;
          n = head_idx;
          for (t = 0; n < PoolN && t < PoolN; t++) begin
            if (shadow_item[n] == rq.item_value) begin
              r.status = pdll_pkg::StOk;
              r.result_node = 4'(n);
              r.read_value = shadow_item[n];
              ok = 1;
              break;
            end
            n = shadow_next[n];
          end
        end
      end
      pdll_pkg::OpFront, pdll_pkg::OpBack: begin
        n = (rq.operation == pdll_pkg::OpFront) ? head_idx : tail_idx;
        if (n >= PoolN) r.status = pdll_pkg::StEmpty;
        else begin
          r.result_node = 4'(n);
          r.read_value = shadow_item[n];
          ok = 1;
        end
      end
      pdll_pkg::OpReadAt, pdll_pkg::OpNext, pdll_pkg::OpPrev: begin
        if (!on_list(h)) r.status = pdll_pkg::StNotInList;
        else begin
          n = (rq.operation == pdll_pkg::OpReadAt) ? h :
              (rq.operation == pdll_pkg::OpNext) ? shadow_next[h] : shadow_prev[h];
          if (n >= PoolN) r.status = pdll_pkg::StNotFound;
          else begin
            r.result_node = 4'(n);
            r.read_value = shadow_item[n];
            ok = 1;
          end
        end
      end
      pdll_pkg::OpClear: begin
        for (t = 0; head_idx < PoolN && t < PoolN; t++) drop_node(head_idx);
      end
      default: ;
    endcase
    r.node_valid = ok;
    if (!ok) begin
      r.result_node = '0;
      r.read_value = '0;
    end
    r.item_count = 5'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full = (list_len >= cap_eff());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  // driver: bursts of requests with random gaps in between
  int burst_left;
  int gap_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_rsps.push_back(list_apply(req_i));
        op_hits[req_i.operation]++;
      end
      if (start_i && busy_o) begin
        // hold the request until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_i <= pending_reqs.pop_front();
        start_i <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every done strobe is one response
  pdll_pkg::rsp_t want_rsp;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", 32'(rsp_o.status), 32'd0);
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp_o.status !== want_rsp.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(want_rsp.status));
        if (rsp_o.result_node !== want_rsp.result_node)
          report_mismatch("result_node", 32'(rsp_o.result_node),
                          32'(want_rsp.result_node));
        if (rsp_o.node_valid !== want_rsp.node_valid)
          report_mismatch("node_valid", 32'(rsp_o.node_valid), 32'(want_rsp.node_valid));
        if (rsp_o.read_value !== want_rsp.read_value)
          report_mismatch("read_value", rsp_o.read_value, want_rsp.read_value);
        if (rsp_o.item_count !== want_rsp.item_count)
          report_mismatch("item_count", 32'(rsp_o.item_count), 32'(want_rsp.item_count));
        if (rsp_o.is_empty !== want_rsp.is_empty)
          report_mismatch("is_empty", 32'(rsp_o.is_empty), 32'(want_rsp.is_empty));
        if (rsp_o.is_full !== want_rsp.is_full)
          report_mismatch("is_full", 32'(rsp_o.is_full), 32'(want_rsp.is_full));
      end
    end
  end

  // apb write of the capacity register, setup then access
  task automatic write_capacity(logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pdll_pkg::AddrCapacity;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = value[4:0];
  endtask

  // wait until every queued request is answered, plus a drain margin
  task automatic drain();
    while (pending_reqs.size() > 0 || start_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic pdll_pkg::req_t make_req(logic [3:0] op, int h, logic [31:0] v);
    pdll_pkg::req_t r;
    r.operation = op;
    r.node_handle = 4'(h);
    r.item_value = v;
    return r;
  endfunction

  // random value, often from a small set so that find hits
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hffff_fff8 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // random request, weighted toward growth
  function automatic pdll_pkg::req_t random_req();
    pdll_pkg::req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.item_value = pick_value();
    r.node_handle = 4'($urandom_range(0, 15));
    if (k < 1) r.operation = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
    else if (k < 3) r.operation = pdll_pkg::OpClear;
    else if (k < 20) r.operation = pdll_pkg::OpPushBack;
    else if (k < 34) r.operation = pdll_pkg::OpPushFront;
    else if (k < 46) r.operation = pdll_pkg::OpInsert;
    else r.operation = 4'($urandom_range(pdll_pkg::OpPopFront, pdll_pkg::OpPrev));
    return r;
  endfunction

  initial begin
    logic [31:0] caps [6];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    rsp_seen = 0;
    burst_left = 0;
    gap_left = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    pool_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cases, extremes, foreign nodes, neighbors, removal, clear
    pending_reqs.push_back(make_req(pdll_pkg::OpPopFront, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpPopBack, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpFind, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpFront, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpBack, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpErase, 15, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpPushBack, 0, 32'hffff_ffff));
    pending_reqs.push_back(make_req(pdll_pkg::OpPushFront, 0, 32'h0));
    pending_reqs.push_back(make_req(pdll_pkg::OpInsert, 15, 32'ha5a5_5a5a));
    pending_reqs.push_back(make_req(pdll_pkg::OpInsert, 3, 32'h1));
    pending_reqs.push_back(make_req(pdll_pkg::OpFind, 0, 32'ha5a5_5a5a));
    pending_reqs.push_back(make_req(pdll_pkg::OpFind, 0, 32'h1234_5678));
    pending_reqs.push_back(make_req(pdll_pkg::OpReadAt, 13, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpNext, 15, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpPrev, 14, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpPrev, 15, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpNext, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpErase, 13, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpPopBack, 0, '0));
    pending_reqs.push_back(make_req(OpUnusedHi, 0, 32'hdead_beef));
    pending_reqs.push_back(make_req(pdll_pkg::OpClear, 0, '0));
    pending_reqs.push_back(make_req(pdll_pkg::OpBack, 0, '0));
    drain();

    // capacity phases: extremes, out-of-range codes, lowering below count
    caps = '{32'd1, 32'd0, 32'd31, 32'd3, 32'd16, 32'd7};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      for (int i = 0; i < 250; i++) pending_reqs.push_back(random_req());
      drain();
    end
    // limit dropped under the live count, then restored
    write_capacity(32'd2);
    for (int i = 0; i < 30; i++) pending_reqs.push_back(random_req());
    drain();
    write_capacity(32'd16);
    drain();

    $display("testbench: %0d responses checked over 8 capacity settings", rsp_seen);
    $display("testbench: push/insert/pop/erase/find %0d/%0d/%0d/%0d/%0d",
             op_hits[pdll_pkg::OpPushBack] + op_hits[pdll_pkg::OpPushFront],
             op_hits[pdll_pkg::OpInsert],
             op_hits[pdll_pkg::OpPopFront] + op_hits[pdll_pkg::OpPopBack],
             op_hits[pdll_pkg::OpErase], op_hits[pdll_pkg::OpFind]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pdll_pkg.sv
hw/rtl/pooled_doubly_linked_list.sv
dv/testbench.sv
